### src/efi_pkg.sv
`default_nettype none
package efi_pkg;

    localparam int ABS_FRAC            = 28;
    localparam int DEF_INPUT_FRAC_BITS = 24;
    localparam int TBL_LAST            = 100;
    localparam int IDX_W               = 7;
    localparam int SRCH_STEPS          = 7;
    localparam int DIV_W               = 27;
    localparam int Q_BITS              = 31;
    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [31:0] ARG_SAT    = 32'h8000_0000;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [31:0] arg;
        t_idx        lo;
        t_idx        hi;
    } t_srch;

    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [63:0]       num;
        logic [DIV_W-1:0]  width;
    } t_num;

    typedef struct packed {
        logic              valid;
        logic              neg;
        logic              zero;
        logic              ovf;
        logic [Q_BITS-1:0] quo;
    } t_quo;

    // decimal table value in units of 1e-9 scaled by s, to Q3.28
    function automatic logic [31:0] xq(input logic [63:0] m, input logic [63:0] s);
        logic [63:0] v;
        v = m * s;
        return 32'((v * 64'd524288 + 64'd976562) / 64'd1953125);
    endfunction

    // decimal table value in units of 1e-11 scaled by s, to Q1.30
    function automatic logic [31:0] yq(input logic [63:0] m, input logic [63:0] s);
        logic [63:0] v;
        v = m * s;
        return 32'((v * 64'd524288 + 64'd24414062) / 64'd48828125);
    endfunction

    localparam logic [31:0] ABSC_ROM [0:TBL_LAST] = '{
        32'd0, xq(3783387,1), xq(7709914,1), xq(1178500,10), xq(1601425,10),
        xq(2040352,10), xq(2495885,10), xq(2968653,10), xq(3459307,10),
        xq(3968525,10), xq(4497008,10), xq(5045486,10), xq(5614715,10),
        xq(6205480,10), xq(6818596,10), xq(7454909,10), xq(8115295,10),
        xq(8800667,10), xq(9511969,10), xq(1025018,100), xq(1101632,100),
        xq(1181145,100), xq(1263667,100), xq(1349310,100), xq(1438193,100),
        xq(1530440,100), xq(1626176,100), xq(1725534,100), xq(1828652,100),
        xq(1935671,100), xq(2046738,100), xq(2162008,100), xq(2281639,100),
        xq(2405796,100), xq(2534651,100), xq(2668380,100), xq(2807169,100),
        xq(2951209,100), xq(3100699,100), xq(3255844,100), xq(3416859,100),
        xq(3583966,100), xq(3757395,100), xq(3937386,100), xq(4124186,100),
        xq(4318054,100), xq(4519256,100), xq(4728071,100), xq(4944786,100),
        xq(5169701,100), xq(5403124,100), xq(5645379,100), xq(5896800,100),
        xq(6157732,100), xq(6428537,100), xq(6709587,100), xq(7001271,100),
        xq(7303990,100), xq(7618162,100), xq(7944220,100), xq(8282614,100),
        xq(8633812,100), xq(8998296,100), xq(9376570,100), xq(9769156,100),
        xq(1017659,1000), xq(1059945,1000), xq(1103830,1000), xq(1149376,1000),
        xq(1196644,1000), xq(1245701,1000), xq(1296614,1000), xq(1349454,1000),
        xq(1404292,1000), xq(1461205,1000), xq(1520272,1000), xq(1581573,1000),
        xq(1645193,1000), xq(1711221,1000), xq(1779746,1000), xq(1850864,1000),
        xq(1924673,1000), xq(2001274,1000), xq(2080774,1000), xq(2163281,1000),
        xq(2248909,1000), xq(2337778,1000), xq(2430008,1000), xq(2525728,1000),
        xq(2625070,1000), xq(2728170,1000), xq(2835170,1000), xq(2946219,1000),
        xq(3061469,1000), xq(3181080,1000), xq(3305216,1000), xq(3434048,1000),
        xq(3567755,1000), xq(3706521,1000), xq(3850536,1000), xq(4000000,1000)
    };

    localparam logic [31:0] ORD_ROM [0:TBL_LAST] = '{
        32'd0, yq(426907434,1), yq(869953340,1), yq(132973284,10),
        yq(180686067,10), yq(230197153,10), yq(281572033,10), yq(334878242,10),
        yq(390185379,10), yq(447565113,10), yq(507091186,10), yq(568839404,10),
        yq(632887618,10), yq(699315688,10), yq(768205444,10), yq(839640613,10),
        yq(913706742,10), yq(990491090,10), yq(107008250,100), yq(115257124,100),
        yq(123804883,100), yq(132660778,100), yq(141834139,100), yq(151334337,100),
        yq(161170754,100), yq(171352743,100), yq(181889576,100), yq(192790394,100),
        yq(204064148,100), yq(215719527,100), yq(227764884,100), yq(240208149,100),
        yq(253056730,100), yq(266317410,100), yq(279996226,100), yq(294098338,100),
        yq(308627885,100), yq(323587825,100), yq(338979770,100), yq(354803790,100),
        yq(371058224,100), yq(387739454,100), yq(404841688,100), yq(422356710,100),
        yq(440273635,100), yq(458578645,100), yq(477254725,100), yq(496281391,100),
        yq(515634428,100), yq(535285634,100), yq(555202571,100), yq(575348359,100),
        yq(595681482,100), yq(616155658,100), yq(636719759,100), yq(657317799,100),
        yq(677889021,100), yq(698368078,100), yq(718685336,100), yq(738767318,100),
        yq(758537287,100), yq(777916009,100), yq(796822665,100), yq(815175962,100),
        yq(832895397,100), yq(849902691,100), yq(866123358,100), yq(881488386,100),
        yq(895935967,100), yq(909413237,100), yq(921877939,100), yq(933299942,100),
        yq(943662512,100), yq(952963249,100), yq(961214608,100), yq(968443923,100),
        yq(974692870,100), yq(980016358,100), yq(984480847,100), yq(988162149,100),
        yq(991142807,100), yq(993509200,100), yq(995348535,100), yq(996745927,100),
        yq(997781755,100), yq(998529475,100), yq(999054014,100), yq(999410828,100),
        yq(999645625,100), yq(999794704,100), yq(999885782,100), yq(999939162,100),
        yq(999969080,100), yq(999985060,100), yq(999993164,100), yq(999997050,100),
        yq(999998805,100), yq(999999548,100), yq(999999841,100), yq(999999948,100),
        yq(999999985,100)
    };

endpackage
`default_nettype wire

### src/efi_search.sv
`default_nettype none
module efi_search (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  efi_pkg::t_srch      i_srch,
    output efi_pkg::t_srch      o_srch
);
    import efi_pkg::*;

    t_srch r_stg [1:SRCH_STEPS];

    assign o_srch = r_stg[SRCH_STEPS];

    // one probe of the abscissa table per stage
    for (genvar k = 0; k < SRCH_STEPS; k++) begin : g_probe
        t_srch      cur;
        t_srch      n_stg;
        logic [IDX_W:0] sum;
        t_idx       mid;

        if (k == 0) begin : g_first
            assign cur = i_srch;
        end else begin : g_next
            assign cur = r_stg[k];
        end

        always_comb begin
            n_stg = cur;
            sum   = {1'b0, cur.lo} + {1'b0, cur.hi};
            mid   = sum[IDX_W:1];
            if ((cur.hi - cur.lo) > t_idx'(1)) begin
                if (ABSC_ROM[mid] > cur.arg) begin
                    n_stg.hi = mid;
                end else begin
                    n_stg.lo = mid;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[k+1].valid <= 1'b0;
            end else begin
                r_stg[k+1].valid <= n_stg.valid;
            end
            r_stg[k+1].neg <= n_stg.neg;
            r_stg[k+1].arg <= n_stg.arg;
            r_stg[k+1].lo  <= n_stg.lo;
            r_stg[k+1].hi  <= n_stg.hi;
        end
    end
endmodule
`default_nettype wire

### src/efi_interp.sv
`default_nettype none
module efi_interp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  efi_pkg::t_srch      i_srch,
    output efi_pkg::t_num       o_num
);
    import efi_pkg::*;

    // stage A: table reads and differences
    logic               r_a_valid, r_a_neg;
    logic signed [32:0] r_da, r_db;
    logic signed [31:0] r_yl, r_yh;
    logic [DIV_W-1:0]   r_a_width;
    // stage B: products
    logic               r_b_valid, r_b_neg;
    logic signed [63:0] r_p1, r_p2;
    logic [DIV_W-1:0]   r_b_width;
    // stage C: sum
    logic               r_c_valid, r_c_neg;
    logic [63:0]        r_num;
    logic [DIV_W-1:0]   r_c_width;

    logic [31:0] xl, xh;
    logic [31:0] n_w;

    always_comb begin
        xl  = ABSC_ROM[i_srch.lo];
        xh  = ABSC_ROM[i_srch.hi];
        n_w = xh - xl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_srch.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
        r_a_neg   <= i_srch.neg;
        r_da      <= $signed({1'b0, i_srch.arg}) - $signed({1'b0, xl});
        r_db      <= $signed({1'b0, xh}) - $signed({1'b0, i_srch.arg});
        r_yl      <= $signed(ORD_ROM[i_srch.lo]);
        r_yh      <= $signed(ORD_ROM[i_srch.hi]);
        r_a_width <= n_w[DIV_W-1:0];

        // operands sign-extended first so the full product is kept
        r_b_neg   <= r_a_neg;
        r_p1      <= 64'(r_yh) * 64'(r_da);
        r_p2      <= 64'(r_yl) * 64'(r_db);
        r_b_width <= r_a_width;

        r_c_neg   <= r_b_neg;
        r_num     <= r_p1 + r_p2;
        r_c_width <= r_b_width;
    end

    assign o_num = '{valid: r_c_valid, neg: r_c_neg, num: r_num, width: r_c_width};
endmodule
`default_nettype wire

### src/efi_div.sv
`default_nettype none
module efi_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  efi_pkg::t_num       i_num,
    output efi_pkg::t_quo       o_quo
);
    import efi_pkg::*;

    logic              r_valid [0:Q_BITS];
    logic              r_neg   [0:Q_BITS];
    logic              r_zero  [0:Q_BITS];
    logic              r_ovf   [0:Q_BITS];
    logic [DIV_W-1:0]  r_rem   [0:Q_BITS];
    logic [DIV_W-1:0]  r_den   [0:Q_BITS];
    logic [Q_BITS-1:0] r_low   [0:Q_BITS];
    logic [Q_BITS-1:0] r_quo   [0:Q_BITS];

    logic [63-Q_BITS:0] hi_part;
    logic               n_ovf;

    always_comb begin
        hi_part = i_num.num[63:Q_BITS];
        // quotient of 2^31 or more always clamps
        n_ovf   = !i_num.num[63] && (hi_part >= (64-Q_BITS)'(i_num.width));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_num.valid;
        end
        r_neg[0]  <= i_num.neg;
        r_zero[0] <= i_num.num[63];
        r_ovf[0]  <= n_ovf;
        r_rem[0]  <= hi_part[DIV_W-1:0];
        r_den[0]  <= i_num.width;
        r_low[0]  <= i_num.num[Q_BITS-1:0];
        r_quo[0]  <= '0;
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < Q_BITS; k++) begin : g_bit
        logic [DIV_W:0]    trial;
        logic [DIV_W:0]    diff;
        logic              take;
        logic [DIV_W-1:0]  n_rem;

        always_comb begin
            trial = {r_rem[k], r_low[k][Q_BITS-1]};
            diff  = trial - {1'b0, r_den[k]};
            take  = trial >= {1'b0, r_den[k]};
            n_rem = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= r_valid[k];
            end
            r_neg[k+1]  <= r_neg[k];
            r_zero[k+1] <= r_zero[k];
            r_ovf[k+1]  <= r_ovf[k];
            r_rem[k+1]  <= n_rem;
            r_den[k+1]  <= r_den[k];
            r_low[k+1]  <= {r_low[k][Q_BITS-2:0], 1'b0};
            r_quo[k+1]  <= {r_quo[k][Q_BITS-2:0], take};
        end
    end

    assign o_quo = '{valid: r_valid[Q_BITS], neg: r_neg[Q_BITS], zero: r_zero[Q_BITS],
                     ovf: r_ovf[Q_BITS], quo: r_quo[Q_BITS]};
endmodule
`default_nettype wire

### src/error_function_interpolator_core.sv
// Throughput: one argument per cycle while busy is low; input register, 7 search stages,
// 3 interpolation stages, 32 divider stages (31 quotient bits) and the output register
// set the depth. Reset: synchronous active low; clears all valid bits, busy is high
// during reset and until the run flag is registered high after it. The receiver
// cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module error_function_interpolator_core #(
    parameter int INPUT_FRAC_BITS = efi_pkg::DEF_INPUT_FRAC_BITS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire signed [31:0]   i_z_value,
    output logic                o_valid,
    output logic signed [31:0]  o_erf_value
);
    import efi_pkg::*;

    localparam int SHIFT  = ABS_FRAC - INPUT_FRAC_BITS;
    localparam int WIDE_W = 32 + SHIFT;

    logic        r_run;
    t_srch       r_in;
    t_srch       srch_out;
    t_num        num;
    t_quo        quo;
    logic        r_valid;
    logic [31:0] r_erf;

    logic [31:0]       mag;
    logic [WIDE_W-1:0] wide;
    logic [31:0]       n_arg;
    logic [31:0]       g;

    always_comb begin
        mag   = i_z_value[31] ? (32'd0 - i_z_value) : i_z_value;
        wide  = WIDE_W'(mag) << SHIFT;
        n_arg = (wide > WIDE_W'(ARG_SAT)) ? ARG_SAT : wide[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_in.valid  <= 1'b0;
        end else begin
            r_run       <= 1'b1;
            r_in.valid  <= start && r_run;
        end
        r_in.neg <= i_z_value[31];
        r_in.arg <= n_arg;
        r_in.lo  <= t_idx'(0);
        r_in.hi  <= t_idx'(TBL_LAST);
    end

    assign busy = !r_run;

    efi_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_srch  (r_in),
        .o_srch  (srch_out)
    );

    efi_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_srch  (srch_out),
        .o_num   (num)
    );

    efi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (num),
        .o_quo   (quo)
    );

    always_comb begin
        if (quo.zero) begin
            g = '0;
        end else if (quo.ovf || ({1'b0, quo.quo} > ONE_Q30)) begin
            g = ONE_Q30;
        end else begin
            g = {1'b0, quo.quo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= quo.valid;
        end
        r_erf <= quo.neg ? (32'd0 - g) : g;
    end

    assign o_valid     = r_valid;
    assign o_erf_value = r_erf;

    a_out_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 44))
        else $error("result without matching transfer");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_erf_value <= 32'sh4000_0000) && (o_erf_value >= -32'sh4000_0000))
        else $error("result beyond unit magnitude");

    a_busy_stays_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !busy)
        else $error("busy rose outside reset");
endmodule
`default_nettype wire

### test/testbench.sv
`default_nettype none
module testbench;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_z_value;
    logic               o_valid;
    logic signed [31:0] o_erf_value;

    logic [31:0] absc_tbl [0:100];
    logic [31:0] ord_tbl  [0:100];
    logic [31:0] erf_expected [$];
    int          mismatch_cnt = 0;
    bit          idle_en = 1;

    error_function_interpolator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_z_value   (i_z_value),
        .o_valid     (o_valid),
        .o_erf_value (o_erf_value)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // decimal table mantissas; scale picked by index range below
    int unsigned absc_m [0:100] = '{
        0, 3783387, 7709914, 1178500, 1601425, 2040352, 2495885, 2968653, 3459307,
        3968525, 4497008, 5045486, 5614715, 6205480, 6818596, 7454909, 8115295,
        8800667, 9511969, 1025018, 1101632, 1181145, 1263667, 1349310, 1438193,
        1530440, 1626176, 1725534, 1828652, 1935671, 2046738, 2162008, 2281639,
        2405796, 2534651, 2668380, 2807169, 2951209, 3100699, 3255844, 3416859,
        3583966, 3757395, 3937386, 4124186, 4318054, 4519256, 4728071, 4944786,
        5169701, 5403124, 5645379, 5896800, 6157732, 6428537, 6709587, 7001271,
        7303990, 7618162, 7944220, 8282614, 8633812, 8998296, 9376570, 9769156,
        1017659, 1059945, 1103830, 1149376, 1196644, 1245701, 1296614, 1349454,
        1404292, 1461205, 1520272, 1581573, 1645193, 1711221, 1779746, 1850864,
        1924673, 2001274, 2080774, 2163281, 2248909, 2337778, 2430008, 2525728,
        2625070, 2728170, 2835170, 2946219, 3061469, 3181080, 3305216, 3434048,
        3567755, 3706521, 3850536, 4000000
    };

    int unsigned ord_m [0:100] = '{
        0, 426907434, 869953340, 132973284, 180686067, 230197153, 281572033,
        334878242, 390185379, 447565113, 507091186, 568839404, 632887618,
        699315688, 768205444, 839640613, 913706742, 990491090, 107008250,
        115257124, 123804883, 132660778, 141834139, 151334337, 161170754,
        171352743, 181889576, 192790394, 204064148, 215719527, 227764884,
        240208149, 253056730, 266317410, 279996226, 294098338, 308627885,
        323587825, 338979770, 354803790, 371058224, 387739454, 404841688,
        422356710, 440273635, 458578645, 477254725, 496281391, 515634428,
        535285634, 555202571, 575348359, 595681482, 616155658, 636719759,
        657317799, 677889021, 698368078, 718685336, 738767318, 758537287,
        777916009, 796822665, 815175962, 832895397, 849902691, 866123358,
        881488386, 895935967, 909413237, 921877939, 933299942, 943662512,
        952963249, 961214608, 968443923, 974692870, 980016358, 984480847,
        988162149, 991142807, 993509200, 995348535, 996745927, 997781755,
        998529475, 999054014, 999410828, 999645625, 999794704, 999885782,
        999939162, 999969080, 999985060, 999993164, 999997050, 999998805,
        999999548, 999999841, 999999948, 999999985
    };

    task automatic build_tables();
        longint unsigned xs, ys;
        for (int k = 0; k <= 100; k++) begin
            xs = (k <= 2) ? 1 : (k <= 18) ? 10 : (k <= 64) ? 100 : 1000;
            ys = (k <= 2) ? 1 : (k <= 17) ? 10 : 100;
            absc_tbl[k] = 32'((longint'(absc_m[k]) * xs * 524288 + 976562) / 1953125);
            ord_tbl[k]  = 32'((longint'(ord_m[k]) * ys * 524288 + 24414062) / 48828125);
        end
    endtask

    function automatic logic [31:0] erf_predict(input logic [31:0] z);
        logic            neg;
        longint unsigned mag, arg;
        int              lo, hi, mid;
        longint          num, width, g;
        neg = z[31];
        mag = neg ? longint'(33'h1_0000_0000 - {1'b0, z}) : longint'(z);
        arg = mag << (28 - 24);
        if (arg > 64'h8000_0000)
            arg = 64'h8000_0000;
        lo = 0;
        hi = 100;
        while (hi - lo > 1) begin
            mid = (hi + lo) / 2;
            if (longint'(absc_tbl[mid]) > arg)
                hi = mid;
            else
                lo = mid;
        end
        num = longint'(ord_tbl[hi]) * (longint'(arg) - longint'(absc_tbl[lo]))
            + longint'(ord_tbl[lo]) * (longint'(absc_tbl[hi]) - longint'(arg));
        width = longint'(absc_tbl[hi]) - longint'(absc_tbl[lo]);
        g = 0;
        if (num > 0 && width > 0)
            g = num / width;
        if (g > 64'h4000_0000)
            g = 64'h4000_0000;
        return neg ? 32'(-g) : 32'(g);
    endfunction

    task automatic report_mismatch(input logic [31:0] got, input logic [31:0] want);
        mismatch_cnt++;
        $display("erf_value mismatch: got %0d expected %0d", $signed(got), $signed(want));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (erf_expected.size() == 0) begin
                report_mismatch(o_erf_value, 32'hxxxx_xxxx);
            end else if (o_erf_value !== erf_expected[0]) begin
                report_mismatch(o_erf_value, erf_expected.pop_front());
            end else begin
                void'(erf_expected.pop_front());
            end
        end
    end

    // one transfer; optional random gap before it
    task automatic send_arg(input logic [31:0] z);
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        start     = 1'b1;
        i_z_value = z;
        do @(posedge i_clk); while (busy);
        erf_expected.push_back(erf_predict(z));
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        wait (erf_expected.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_arg();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'($urandom_range(0, 32'h0A00_0000)) - 32'h0500_0000;
            2:       return {absc_tbl[$urandom_range(0, 100)] >> 4} + $urandom_range(0, 2)
                            - 1;
            default: return 32'($urandom_range(0, 32'h0440_0000)) - 32'h0220_0000;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] pts [$] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0001, 32'h0400_0000, 32'h0400_0001,
            32'hFC00_0000, 32'h0410_0000, 32'h0800_0000, 32'hF800_0000,
            32'h0100_0000, 32'hFF00_0000, 32'h0000_F000, 32'h0001_0000,
            32'h0010_0000, 32'h0040_0000, 32'h0200_0000, 32'hFE00_0000,
            32'h5555_5555, 32'hAAAA_AAAA};
        foreach (pts[k])
            send_arg(pts[k]);
        send_arg(absc_tbl[1] >> 4);
        send_arg(absc_tbl[99] >> 4);
        drain();
    endtask

    task automatic test_random_idle(input int n);
        repeat (n) send_arg(rand_arg());
    endtask

    task automatic test_random_burst(input int n);
        idle_en = 0;
        repeat (n) send_arg(rand_arg());
        drain();
    endtask

    initial begin
        start     = 1'b0;
        i_z_value = '0;
        i_rst_n   = 1'b0;
        build_tables();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_idle(700);
        drain();
        test_random_idle(700);
        test_random_burst(330);

        if (mismatch_cnt == 0 && erf_expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire

### error_function_interpolator_core.f
src/efi_pkg.sv
src/efi_search.sv
src/efi_interp.sv
src/efi_div.sv
src/error_function_interpolator_core.sv
test/testbench.sv
